[src/utf8dw_pkg.sv]
// Shared codes, types and the display width lookup for the UTF-8 decoder.
package utf8dw_pkg;

  localparam int CP_W = 21;

  // Operation selector on the input side
  localparam logic [1:0] FUNC_OPEN   = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;

  // Result status
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic [3:0][7:0] seq_bytes;
    logic [2:0]      bytes_held;
    logic [2:0]      seq_len;
  } dec_state_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CP_W-1:0] code_point;
    logic [1:0]      width;
    logic [2:0]      length;
  } dec_result_t;

  function automatic logic in_rng(logic [CP_W-1:0] v, logic [CP_W-1:0] lo,
                                  logic [CP_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Display columns of a decoded code point: controls, wide blocks, combining marks.
  function automatic logic [1:0] cp_width(logic [CP_W-1:0] wc);
    logic ctrl;
    logic wide;
    logic zero;
    ctrl = (wc < 21'h20) || in_rng(wc, 21'h7f, 21'h9f);
    wide = in_rng(wc, 21'h1100, 21'h115f) || (wc == 21'h2329) || (wc == 21'h232a) ||
           (in_rng(wc, 21'h2e80, 21'ha4cf) && (wc != 21'h303f)) ||
           in_rng(wc, 21'hac00, 21'hd7a3) || in_rng(wc, 21'hf900, 21'hfaff) ||
           in_rng(wc, 21'hfe10, 21'hfe19) || in_rng(wc, 21'hfe30, 21'hfe6f) ||
           in_rng(wc, 21'hff00, 21'hff60) || in_rng(wc, 21'hffe0, 21'hffe6) ||
           in_rng(wc, 21'h20000, 21'h2fffd) || in_rng(wc, 21'h30000, 21'h3fffd);
    zero = in_rng(wc, 21'h0300, 21'h036f) || in_rng(wc, 21'h0483, 21'h0489) ||
           in_rng(wc, 21'h0591, 21'h05bd) || in_rng(wc, 21'h200b, 21'h200f) ||
           in_rng(wc, 21'h2028, 21'h202e) || in_rng(wc, 21'h2060, 21'h2069) ||
           in_rng(wc, 21'hfe00, 21'hfe0f) || (wc == 21'hfeff);
    if (ctrl) return 2'd0;
    if (wide) return 2'd2;
    if (zero) return 2'd0;
    return 2'd1;
  endfunction

endpackage

[src/utf8dw_step.sv]
// Next-state and result logic for one byte of the UTF-8 decoder.
module utf8dw_step (
  input  utf8dw_pkg::dec_state_t  st,
  input  logic [1:0]              func,
  input  logic [7:0]              byte_in,
  output utf8dw_pkg::dec_state_t  st_next,
  output utf8dw_pkg::dec_result_t res
);

  logic [2:0]                   lead_len;
  logic                         app_ok;
  logic [2:0]                   held_inc;
  logic [3:0][7:0]              app_bytes;
  logic [utf8dw_pkg::CP_W-1:0]  cp_dec;
  logic [1:0]                   wid_dec;

  // Classify a lead byte; zero means invalid
  always_comb begin
    priority if (byte_in[7] == 1'b0)         lead_len = 3'd1;
    else if (byte_in[7:5] == 3'b110)        lead_len = 3'd2;
    else if (byte_in[7:4] == 4'b1110)       lead_len = 3'd3;
    else if (byte_in[7:3] == 5'b11110)      lead_len = 3'd4;
    else                                    lead_len = 3'd0;
  end

  assign app_ok   = (byte_in[7:6] == 2'b10) && (st.bytes_held < st.seq_len);
  assign held_inc = 3'(st.bytes_held + 3'd1);

  always_comb begin
    app_bytes = st.seq_bytes;
    app_bytes[st.bytes_held[1:0]] = byte_in;
  end

  // Assemble the code point from the bytes including the one just appended
  always_comb begin
    unique case (st.seq_len)
      3'd2: cp_dec = {10'd0, app_bytes[0][4:0], app_bytes[1][5:0]};
      3'd3: cp_dec = {5'd0, app_bytes[0][3:0], app_bytes[1][5:0], app_bytes[2][5:0]};
      3'd4: cp_dec = {app_bytes[0][2:0], app_bytes[1][5:0], app_bytes[2][5:0],
                      app_bytes[3][5:0]};
      default: cp_dec = {13'd0, app_bytes[0]};
    endcase
  end

  assign wid_dec = (st.seq_len == 3'd1) ? {1'b0, (app_bytes[0] != 8'd0)}
                                        : utf8dw_pkg::cp_width(cp_dec);

  always_comb begin
    st_next        = st;
    res.status     = utf8dw_pkg::ST_ERR;
    res.code_point = '0;
    res.width      = 2'd0;
    unique case (func)
      utf8dw_pkg::FUNC_OPEN: begin
        st_next.seq_bytes = '0;
        if (lead_len == 3'd0) begin
          st_next.bytes_held = 3'd0;
          st_next.seq_len    = 3'd0;
        end else begin
          st_next.seq_bytes[0] = byte_in;
          st_next.bytes_held   = 3'd1;
          st_next.seq_len      = lead_len;
          if (lead_len == 3'd1) begin
            res.status     = utf8dw_pkg::ST_DONE;
            res.code_point = {13'd0, byte_in};
            res.width      = {1'b0, (byte_in != 8'd0)};
          end else begin
            res.status = utf8dw_pkg::ST_MORE;
          end
        end
      end
      utf8dw_pkg::FUNC_APPEND: begin
        if (app_ok) begin
          st_next.seq_bytes  = app_bytes;
          st_next.bytes_held = held_inc;
          if (held_inc < st.seq_len) begin
            res.status = utf8dw_pkg::ST_MORE;
          end else begin
            res.status     = utf8dw_pkg::ST_DONE;
            res.code_point = cp_dec;
            res.width      = wid_dec;
          end
        end
      end
      utf8dw_pkg::FUNC_SET: begin
        st_next.seq_bytes    = '0;
        st_next.seq_bytes[0] = byte_in;
        st_next.bytes_held   = 3'd1;
        st_next.seq_len      = 3'd1;
        res.status           = utf8dw_pkg::ST_DONE;
        res.code_point       = {13'd0, byte_in};
        res.width            = 2'd1;
      end
      default: begin
        // unused selector: hold state, report error
      end
    endcase
    res.length = st_next.bytes_held;
  end

endmodule

[src/utf8_decode_display_width.sv]
// Top level of the UTF-8 decoder with display width: state, output and skid registers.
//
// Input channel s_*: one item per byte of the stream. s_tuser carries the
// operation (open a character, append a continuation byte, set a raw byte),
// s_tdata the byte itself.
// Output channel m_*: exactly one result item per input item, in order.
// m_tuser carries the status (more needed, done, error); m_tdata carries the
// code point, the display width and the number of bytes held.
//
// Output: each result is registered in the output register, or in the skid
// register below while the output stalls. Throughput: one item per cycle while
// s_tready is high; the decoder state, the code point assembly and the width
// lookup all settle combinationally between the input handshake and the output register.
// Stall: when the receiver holds m_tready low, one more result parks in a
// skid register; s_tready drops only while that skid register is full.
// Reset (rst, synchronous): empties both output registers and clears the
// byte count and expected length, so the first append after reset errors.
module utf8_decode_display_width (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [20:0] code_point, [22:21] width, [25:23] length, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  utf8dw_pkg::dec_state_t  st;
  utf8dw_pkg::dec_state_t  st_next;
  utf8dw_pkg::dec_result_t res;
  utf8dw_pkg::dec_result_t out_res;
  utf8dw_pkg::dec_result_t skid_res;
  logic                    out_valid;
  logic                    skid_valid;
  logic                    accept;
  logic                    take;
  logic                    out_load;

  utf8dw_step u_step (
    .st      (st),
    .func    (s_tuser),
    .byte_in (s_tdata),
    .st_next (st_next),
    .res     (res)
  );

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;
  // Output register is free when empty or being drained this cycle
  assign out_load = !out_valid || take;

  // Control state and collected bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      st.seq_bytes  <= '0;
      st.bytes_held <= 3'd0;
      st.seq_len    <= 3'd0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (accept) begin
        st.seq_bytes  <= st_next.seq_bytes;
        st.bytes_held <= st_next.bytes_held;
        st.seq_len    <= st_next.seq_len;
      end
      if (out_load) begin
        // Drain the skid first; it blocks new items while full
        out_valid  <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload: result values
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {6'd0, out_res.length, out_res.width, out_res.code_point};

  // The skid register only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A skid fill needs a stalled output in the previous cycle
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid register filled without a stall");

  // Byte count never passes the expected length
  a_held_in_len: assert property (@(posedge clk) disable iff (rst)
    (st.bytes_held <= st.seq_len) && (st.seq_len <= 3'd4))
    else $error("decoder byte count out of range");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the UTF-8 decoder with display width.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Selector value with no operation behind it; the block must answer with an error
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_SHOWN    = 10;

  // Display column spans, checked in order, first hit wins: {lo, hi, columns}.
  // Controls come first, then the one hole in the wide CJK block, then the
  // wide spans, then the zero-width marks; anything else is one column.
  localparam int NSPAN = 22;
  localparam logic [0:NSPAN-1][43:0] COL_SPANS = {
    {21'h00000, 21'h0001f, 2'd0}, {21'h0007f, 21'h0009f, 2'd0},
    {21'h0303f, 21'h0303f, 2'd1},
    {21'h01100, 21'h0115f, 2'd2}, {21'h02329, 21'h0232a, 2'd2},
    {21'h02e80, 21'h0a4cf, 2'd2}, {21'h0ac00, 21'h0d7a3, 2'd2},
    {21'h0f900, 21'h0faff, 2'd2}, {21'h0fe10, 21'h0fe19, 2'd2},
    {21'h0fe30, 21'h0fe6f, 2'd2}, {21'h0ff00, 21'h0ff60, 2'd2},
    {21'h0ffe0, 21'h0ffe6, 2'd2}, {21'h20000, 21'h2fffd, 2'd2},
    {21'h30000, 21'h3fffd, 2'd2},
    {21'h00300, 21'h0036f, 2'd0}, {21'h00483, 21'h00489, 2'd0},
    {21'h00591, 21'h005bd, 2'd0}, {21'h0200b, 21'h0200f, 2'd0},
    {21'h02028, 21'h0202e, 2'd0}, {21'h02060, 21'h02069, 2'd0},
    {21'h0fe00, 21'h0fe0f, 2'd0}, {21'h0feff, 21'h0feff, 2'd0}
  };

  // One row of the directed part: when known is set, res is the literal answer
  typedef struct packed {
    logic                    known;
    logic [1:0]              op;
    logic [7:0]              data;
    utf8dw_pkg::dec_result_t res;
  } stim_row_t;

  localparam utf8dw_pkg::dec_result_t FROM_MODEL = '0;
  localparam int NDIR = 26;

  localparam stim_row_t [0:NDIR-1] DIRECTED = {
    // append straight after reset: nothing open
    {1'b1, utf8dw_pkg::FUNC_APPEND, 8'h80, utf8dw_pkg::ST_ERR,  21'h00000, 2'd0, 3'd0},
    // ASCII open: NUL has no width, DEL still counts as one column
    {1'b1, utf8dw_pkg::FUNC_OPEN,   8'h00, utf8dw_pkg::ST_DONE, 21'h00000, 2'd0, 3'd1},
    {1'b1, utf8dw_pkg::FUNC_OPEN,   8'h7f, utf8dw_pkg::ST_DONE, 21'h0007f, 2'd1, 3'd1},
    // append to a finished one-byte character
    {1'b1, utf8dw_pkg::FUNC_APPEND, 8'h80, utf8dw_pkg::ST_ERR,  21'h00000, 2'd0, 3'd1},
    // raw set is always one column, NUL included
    {1'b1, utf8dw_pkg::FUNC_SET,    8'h00, utf8dw_pkg::ST_DONE, 21'h00000, 2'd1, 3'd1},
    {1'b1, utf8dw_pkg::FUNC_SET,    8'hff, utf8dw_pkg::ST_DONE, 21'h000ff, 2'd1, 3'd1},
    // invalid lead clears everything
    {1'b1, utf8dw_pkg::FUNC_OPEN,   8'hff, utf8dw_pkg::ST_ERR,  21'h00000, 2'd0, 3'd0},
    // two-byte character with a stray non-continuation byte in between
    {1'b1, utf8dw_pkg::FUNC_OPEN,   8'hc3, utf8dw_pkg::ST_MORE, 21'h00000, 2'd0, 3'd1},
    {1'b1, utf8dw_pkg::FUNC_APPEND, 8'h41, utf8dw_pkg::ST_ERR,  21'h00000, 2'd0, 3'd1},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'ha9, FROM_MODEL},
    // first CJK ideograph, two columns
    {1'b1, utf8dw_pkg::FUNC_OPEN,   8'he4, utf8dw_pkg::ST_MORE, 21'h00000, 2'd0, 3'd1},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hb8, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'h80, FROM_MODEL},
    // highest Unicode scalar, then overflow the full sequence
    {1'b0, utf8dw_pkg::FUNC_OPEN,   8'hf4, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'h8f, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbf, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbf, FROM_MODEL},
    {1'b1, utf8dw_pkg::FUNC_APPEND, 8'hbf, utf8dw_pkg::ST_ERR,  21'h00000, 2'd0, 3'd4},
    // unused selector leaves the state alone
    {1'b1, FUNC_UNUSED,             8'h55, utf8dw_pkg::ST_ERR,  21'h00000, 2'd0, 3'd4},
    // byte order mark, zero width
    {1'b0, utf8dw_pkg::FUNC_OPEN,   8'hef, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbb, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbf, FROM_MODEL},
    // all-ones four-byte form, top of the code point field
    {1'b0, utf8dw_pkg::FUNC_OPEN,   8'hf7, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbf, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbf, FROM_MODEL},
    {1'b0, utf8dw_pkg::FUNC_APPEND, 8'hbf, FROM_MODEL}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_in
  logic [1:0]  s_tuser = 2'd0;    // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [20:0] code_point, [22:21] width, [25:23] length
  logic [1:0]  m_tuser;           // [1:0] status

  utf8_decode_display_width u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: collected bytes, how many are held, how many the lead asked for
  logic [7:0]  held_bytes [4];
  logic [2:0]  held_cnt = 3'd0;
  logic [2:0]  want_cnt = 3'd0;

  utf8dw_pkg::dec_result_t decoded_due [$];   // results owed by the block, oldest first
  int          fail_count = 0;
  int          shown = 0;
  int          sent_count = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;       // when set, the sender adds no idle gaps and the receiver never stalls

  initial begin
    for (int k = 0; k < 4; k++) held_bytes[k] = 8'h00;
  end

  // Advance the predicted decoder by one item and return its result
  function automatic utf8dw_pkg::dec_result_t decode_byte(logic [1:0] op, logic [7:0] data);
    utf8dw_pkg::dec_result_t r;
    logic [2:0]  lead_n;
    logic [20:0] cp;
    r = '0;
    r.status = utf8dw_pkg::ST_ERR;
    case (op)
      utf8dw_pkg::FUNC_OPEN: begin
        for (int k = 0; k < 4; k++) held_bytes[k] = 8'h00;
        held_cnt = 3'd0;
        want_cnt = 3'd0;
        if (!data[7])                  lead_n = 3'd1;
        else if (data[7:5] == 3'b110)  lead_n = 3'd2;
        else if (data[7:4] == 4'b1110) lead_n = 3'd3;
        else if (data[7:3] == 5'b11110) lead_n = 3'd4;
        else                           lead_n = 3'd0;
        if (lead_n != 3'd0) begin
          held_bytes[0] = data;
          held_cnt = 3'd1;
          want_cnt = lead_n;
          if (lead_n == 3'd1) begin
            r.status = utf8dw_pkg::ST_DONE;
            r.code_point = {13'd0, data};
            r.width = (data == 8'h00) ? 2'd0 : 2'd1;
          end else begin
            r.status = utf8dw_pkg::ST_MORE;
          end
        end
      end
      utf8dw_pkg::FUNC_APPEND: begin
        if (data[7:6] == 2'b10 && held_cnt < want_cnt && held_cnt < 3'd4) begin
          held_bytes[held_cnt[1:0]] = data;
          held_cnt = held_cnt + 3'd1;
          if (held_cnt < want_cnt) begin
            r.status = utf8dw_pkg::ST_MORE;
          end else begin
            case (want_cnt)
              3'd2: cp = {10'd0, held_bytes[0][4:0], held_bytes[1][5:0]};
              3'd3: cp = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], held_bytes[2][5:0]};
              default: cp = {held_bytes[0][2:0], held_bytes[1][5:0],
                             held_bytes[2][5:0], held_bytes[3][5:0]};
            endcase
            r.status = utf8dw_pkg::ST_DONE;
            r.code_point = cp;
            r.width = 2'd1;
            for (int i = NSPAN - 1; i >= 0; i--) begin
              // walk backwards so the earliest matching span is the one kept
              if (cp >= COL_SPANS[i][43:23] && cp <= COL_SPANS[i][22:2])
                r.width = COL_SPANS[i][1:0];
            end
          end
        end
      end
      utf8dw_pkg::FUNC_SET: begin
        for (int k = 0; k < 4; k++) held_bytes[k] = 8'h00;
        held_bytes[0] = data;
        held_cnt = 3'd1;
        want_cnt = 3'd1;
        r.status = utf8dw_pkg::ST_DONE;
        r.code_point = {13'd0, data};
        r.width = 2'd1;
      end
      default: ;
    endcase
    r.length = held_cnt;
    return r;
  endfunction

  // Offer one item, hold it until accepted, then log what the block owes for it
  task automatic send_item(logic [1:0] op, logic [7:0] data, logic known,
                           utf8dw_pkg::dec_result_t fixed_res);
    utf8dw_pkg::dec_result_t predicted;
    while (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    predicted = decode_byte(op, data);
    decoded_due.push_back(known ? fixed_res : predicted);
    sent_count++;
  endtask

  // Encode one code point, near a width boundary or anywhere, and send it,
  // either intact or broken (cut short, stray byte, one append too many)
  task automatic send_char(bit broken);
    logic [20:0] cp;
    logic [7:0]  seqb [4];
    logic [7:0]  stray;
    int          n, minn, idx, mode, cut, bad_at, pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      idx = $urandom_range(NSPAN - 1);
      cp = ($urandom_range(1) ? COL_SPANS[idx][43:23] : COL_SPANS[idx][22:2]) +
           21'($urandom_range(2)) - 21'd1;
    end else if (pick < 75) begin
      cp = 21'($urandom_range(16'hffff));
    end else if (pick < 90) begin
      cp = 21'($urandom_range(21'h3ffff));
    end else begin
      cp = 21'($urandom_range(21'h1fffff));
    end
    minn = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    // an occasional overlong form goes through unchecked
    n = ($urandom_range(9) == 0) ? $urandom_range(4, minn) : minn;
    case (n)
      1: seqb[0] = cp[7:0];
      2: seqb[0] = {3'b110, cp[10:6]};
      3: seqb[0] = {4'b1110, cp[15:12]};
      default: seqb[0] = {5'b11110, cp[20:18]};
    endcase
    for (int j = 1; j < n; j++) seqb[j] = {2'b10, 6'(cp >> (6 * (n - 1 - j)))};
    mode = broken ? $urandom_range(2) : 3;
    cut = (mode == 0) ? $urandom_range(n, 1) : n;
    bad_at = (mode == 1) ? $urandom_range(3, 1) : 4;
    for (int j = 0; j < cut; j++) begin
      if (j == bad_at) begin
        stray = 8'($urandom_range(255));
        if (stray[7:6] == 2'b10) stray[6] = 1'b1;
        send_item(utf8dw_pkg::FUNC_APPEND, stray, 1'b0, FROM_MODEL);
      end
      send_item((j == 0) ? utf8dw_pkg::FUNC_OPEN : utf8dw_pkg::FUNC_APPEND, seqb[j],
                1'b0, FROM_MODEL);
    end
    if (mode == 2)
      send_item(utf8dw_pkg::FUNC_APPEND, {2'b10, 6'($urandom_range(63))}, 1'b0,
                FROM_MODEL);
  endtask

  // Receiver: stall now and then, never during the calm stretch
  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 12);

  // Compare each accepted result with the oldest one owed
  utf8dw_pkg::dec_result_t got_res;
  utf8dw_pkg::dec_result_t want_res;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = {m_tuser, m_tdata[20:0], m_tdata[22:21], m_tdata[25:23]};
      if (decoded_due.size() == 0) begin
        fail_count++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected result: status %0d cp %h width %0d length %0d",
                   got_res.status, got_res.code_point, got_res.width, got_res.length);
        end
      end else begin
        want_res = decoded_due.pop_front();
        if (got_res !== want_res) begin
          fail_count++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("mismatch: status %0d/%0d cp %h/%h width %0d/%0d length %0d/%0d",
                     want_res.status, got_res.status,
                     want_res.code_point, got_res.code_point,
                     want_res.width, got_res.width,
                     want_res.length, got_res.length);
          end
        end
      end
    end
  end

  // Watchdog: give up when neither side has moved an item for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int        pick;
    int        next_drain;
    next_drain = 350;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      row = DIRECTED[i];
      send_item(row.op, row.data, row.known, row.res);
    end

    // Mostly well-formed characters, some broken ones, the rest noise
    while (sent_count < RANDOM_ITEMS) begin
      calm = (sent_count >= 600 && sent_count < 900);
      if (sent_count >= next_drain) begin
        // hold off until the block has delivered everything
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_due.size() != 0) @(posedge clk);
        next_drain += 350;
      end
      pick = $urandom_range(99);
      if (pick < 65)
        send_char(1'b0);
      else if (pick < 80)
        send_char(1'b1);
      else
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, FROM_MODEL);
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[utf8_decode_display_width.f]
src/utf8dw_pkg.sv
src/utf8dw_step.sv
src/utf8_decode_display_width.sv
tb/sv/tb_top.sv
